// ===== hw/rtl/twcb_pkg.sv =====
// ----------------------------------------------------------------------------
// twcb_pkg: shared types and constants of the triple witness cube builder
// Field widths, configuration codes and the base-3 digit helper.
// ----------------------------------------------------------------------------
package twcb_pkg;

  localparam int ROW_W  = 13;   // input row value
  localparam int IDX_W  = 3;    // row index on the result ports
  localparam int BITS_W = 8;    // cube bit mask on the result ports
  localparam int CNT_W  = 10;   // running set-bit count
  localparam int CFG_W  = 4;    // configuration register width
  localparam int COLS_W = 5;    // effective column count, up to MAX_DIGITS
  localparam int QUO_W  = 12;   // quotient of a row value by three
  localparam int RES_W  = 2 * IDX_W + BITS_W + CNT_W + 1;

  // configuration register indexes
  localparam logic CFG_IDX_ROWS = 1'b0;
  localparam logic CFG_IDX_COLS = 1'b1;

  // base-3 digit values
  localparam logic [1:0] DIG_ZERO = 2'd0;
  localparam logic [1:0] DIG_ONE  = 2'd1;
  localparam logic [1:0] DIG_TWO  = 2'd2;

  // ceil(2^13 / 3), reciprocal for the divide by three
  localparam logic [QUO_W-1:0] RECIP3 = 12'd2731;

  typedef struct packed {
    logic [CFG_W-1:0]  rows;   // 1 .. MAX_ROWS_STORED
    logic [COLS_W-1:0] cols;   // 1 .. MAX_DIGITS
  } cfg_t;

  typedef struct packed {
    logic [QUO_W-1:0] quo;
    logic [1:0]       rem;
  } div3_t;

  // v / 3 and v % 3 by reciprocal multiply with one correction step
  function automatic div3_t div3(input logic [ROW_W-1:0] v);
    logic [ROW_W+QUO_W-1:0] prod;
    logic [QUO_W-1:0]       q;
    logic [ROW_W-1:0]       r;
    div3_t                  res;
    prod = (ROW_W + QUO_W)'(v) * (ROW_W + QUO_W)'(RECIP3);
    q    = prod[ROW_W+QUO_W-1:ROW_W];
    r    = v - ROW_W'(q) - ROW_W'({q, 1'b0});
    if (r >= ROW_W'(3)) begin
      q = q + QUO_W'(1);
      r = r - ROW_W'(3);
    end
    res.quo = q;
    res.rem = r[1:0];
    return res;
  endfunction

endpackage

// ===== hw/rtl/twcb_queue.sv =====
// ----------------------------------------------------------------------------
// twcb_queue: small synchronous FIFO
// Flop storage, combinational head, one push/pop per cycle when not full/empty.
// ----------------------------------------------------------------------------
module twcb_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/twcb_front.sv =====
// ----------------------------------------------------------------------------
// twcb_front: row intake and digit classification
// Takes one row, splits it into base-3 digits one per cycle and hands the
// per-column digit flags, slot and end-of-puzzle mark to the back end.
// ----------------------------------------------------------------------------
module twcb_front import twcb_pkg::*; #(
  parameter  int ROW_SLOTS  = 8,
  parameter  int MAX_DIGITS = 8,
  localparam int RIDX_W     = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1,
  localparam int JOB_W      = 1 + RIDX_W + 3 * MAX_DIGITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_push,
  input  logic [ROW_W-1:0] in_row_value,
  output logic             in_full,
  output logic             job_valid,
  output logic [JOB_W-1:0] job_data,
  input  logic             job_ready
);

  localparam int DIG_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [ROW_W-1:0]      val_r, val_nxt;
  logic [DIG_W-1:0]      dig_r, dig_nxt;
  logic [MAX_DIGITS-1:0] is0_r, is0_nxt, is1_r, is1_nxt, is2_r, is2_nxt;
  logic [RIDX_W-1:0]     slot_r, slot_nxt;
  logic                  final_r, final_nxt;
  logic [CFG_W-1:0]      loaded_r, loaded_nxt;
  logic [CFG_W-1:0]      slot_w, next_cnt;
  logic                  accept;
  div3_t                 dv;

  assign in_full   = !((state_r == ST_IDLE) || ((state_r == ST_PUSH) && job_ready));
  assign accept    = in_push && !in_full;
  assign job_valid = (state_r == ST_PUSH);
  assign job_data  = {final_r, slot_r, is0_r, is1_r, is2_r};

  always_comb begin
    // a full store keeps overwriting its last slot
    slot_w     = (loaded_r >= cfg.rows) ? cfg.rows - CFG_W'(1) : loaded_r;
    next_cnt   = slot_w + CFG_W'(1);
    dv         = div3(val_r);
    state_nxt  = state_r;
    val_nxt    = val_r;
    dig_nxt    = dig_r;
    is0_nxt    = is0_r;
    is1_nxt    = is1_r;
    is2_nxt    = is2_r;
    slot_nxt   = slot_r;
    final_nxt  = final_r;
    loaded_nxt = loaded_r;
    unique case (state_r)
      ST_IDLE: begin
      end
      ST_CONV: begin
        val_nxt        = ROW_W'(dv.quo);
        is0_nxt[dig_r] = (dv.rem == DIG_ZERO);
        is1_nxt[dig_r] = (dv.rem == DIG_ONE);
        is2_nxt[dig_r] = (dv.rem == DIG_TWO);
        dig_nxt        = dig_r + DIG_W'(1);
        if (dig_r == DIG_W'(MAX_DIGITS - 1)) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (job_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (accept) begin
      state_nxt  = ST_CONV;
      val_nxt    = in_row_value;
      dig_nxt    = '0;
      slot_nxt   = slot_w[RIDX_W-1:0];
      final_nxt  = (next_cnt == cfg.rows);
      loaded_nxt = (next_cnt == cfg.rows) ? '0 : next_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      loaded_r <= '0;
    end else begin
      state_r  <= state_nxt;
      loaded_r <= loaded_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    dig_r   <= dig_nxt;
    is0_r   <= is0_nxt;
    is1_r   <= is1_nxt;
    is2_r   <= is2_nxt;
    slot_r  <= slot_nxt;
    final_r <= final_nxt;
  end

endmodule

// ===== hw/rtl/twcb_back.sv =====
// ----------------------------------------------------------------------------
// twcb_back: row store and pair walk
// Files classified rows into per-row lanes; on a puzzle's last row it walks
// every (r1,r2) pair (one line a cycle while res_ready) and counts set bits.
// ----------------------------------------------------------------------------
module twcb_back import twcb_pkg::*; #(
  parameter  int ROW_SLOTS  = 8,
  parameter  int MAX_DIGITS = 8,
  localparam int RIDX_W     = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1,
  localparam int JOB_W      = 1 + RIDX_W + 3 * MAX_DIGITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             job_empty,
  input  logic [JOB_W-1:0] job_data,
  output logic             job_pop,
  output logic             res_valid,
  output logic [RES_W-1:0] res_data,
  input  logic             res_ready
);

  localparam int PC_W = $clog2(ROW_SLOTS + 1);

  localparam logic ST_LOAD = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic                  state_r, state_nxt;
  logic [MAX_DIGITS-1:0] is0_lane_r [ROW_SLOTS];
  logic [MAX_DIGITS-1:0] is1_lane_r [ROW_SLOTS];
  logic [MAX_DIGITS-1:0] is2_lane_r [ROW_SLOTS];
  logic [RIDX_W-1:0]     r1_r, r1_nxt, r2_r, r2_nxt;
  logic                  p_valid_r;
  logic [RIDX_W-1:0]     p_r1_r, p_r2_r;
  logic [ROW_SLOTS-1:0]  p_bits_r;
  logic                  p_last_r;
  logic [CNT_W-1:0]      total_r;

  logic                  j_final;
  logic [RIDX_W-1:0]     j_slot;
  logic [MAX_DIGITS-1:0] j_is0, j_is1, j_is2;
  logic [MAX_DIGITS-1:0] colmask, x, y;
  logic [ROW_SLOTS-1:0]  bits;
  logic [CFG_W-1:0]      rows_m1;
  logic                  last_pair, issue, p_adv;
  logic [PC_W-1:0]       pc;
  logic [CNT_W-1:0]      count;

  assign j_final = job_data[JOB_W-1];
  assign j_slot  = job_data[3*MAX_DIGITS +: RIDX_W];
  assign j_is0   = job_data[2*MAX_DIGITS +: MAX_DIGITS];
  assign j_is1   = job_data[MAX_DIGITS +: MAX_DIGITS];
  assign j_is2   = job_data[0 +: MAX_DIGITS];

  assign job_pop   = (state_r == ST_LOAD) && !job_empty;
  assign rows_m1   = cfg.rows - CFG_W'(1);
  assign last_pair = (CFG_W'(r1_r) == rows_m1) && (CFG_W'(r2_r) == rows_m1);
  assign p_adv     = p_valid_r && res_ready;
  assign issue     = (state_r == ST_WALK) && (!p_valid_r || res_ready);

  // witness column: exactly two of (r1 digit 0, r2 digit 1, r3 digit 2)
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      colmask[i] = (COLS_W'(i) < cfg.cols);
    end
    x = is0_lane_r[r1_r] & colmask;
    y = is1_lane_r[r2_r] & colmask;
    for (int k = 0; k < ROW_SLOTS; k++) begin
      bits[k] = !(|((x & y & ~is2_lane_r[k]) | ((x ^ y) & is2_lane_r[k])))
                && (CFG_W'(k) < cfg.rows);
    end
  end

  always_comb begin
    pc = '0;
    for (int k = 0; k < ROW_SLOTS; k++) begin
      pc = pc + PC_W'(p_bits_r[k]);
    end
    count = total_r + CNT_W'(pc);
  end

  assign res_valid = p_valid_r;
  assign res_data  = {IDX_W'(p_r1_r), IDX_W'(p_r2_r), BITS_W'(p_bits_r), count, p_last_r};

  always_comb begin
    state_nxt = state_r;
    r1_nxt    = r1_r;
    r2_nxt    = r2_r;
    unique case (state_r)
      ST_LOAD: begin
        if (job_pop && j_final) begin
          state_nxt = ST_WALK;
          r1_nxt    = '0;
          r2_nxt    = '0;
        end
      end
      ST_WALK: begin
        if (issue) begin
          if (CFG_W'(r2_r) == rows_m1) begin
            r2_nxt = '0;
            r1_nxt = r1_r + RIDX_W'(1);
            if (last_pair) begin
              state_nxt = ST_LOAD;
            end
          end else begin
            r2_nxt = r2_r + RIDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      p_valid_r <= 1'b0;
      total_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (issue) begin
        p_valid_r <= 1'b1;
      end else if (p_adv) begin
        p_valid_r <= 1'b0;
      end
      if (p_adv) begin
        total_r <= p_last_r ? '0 : count;
      end
    end
  end

  always_ff @(posedge clk) begin
    r1_r <= r1_nxt;
    r2_r <= r2_nxt;
    if (job_pop) begin
      is0_lane_r[j_slot] <= j_is0;
      is1_lane_r[j_slot] <= j_is1;
      is2_lane_r[j_slot] <= j_is2;
    end
    if (issue) begin
      p_r1_r   <= r1_r;
      p_r2_r   <= r2_r;
      p_bits_r <= bits;
      p_last_r <= last_pair;
    end
  end

endmodule

// ===== hw/rtl/triple_witness_cube_builder_unit.sv =====
// ----------------------------------------------------------------------------
// triple_witness_cube_builder_unit: puzzle row loader and cube line builder
//
// Input channel (push/full): one beat carries one puzzle row as a base-3
// number. A beat is taken when in_push is high and in_full is low. The front
// end splits the row into digits before it takes the next one; a two-entry
// queue lets it run ahead of the back end while a pair walk is under way.
// Result channel (empty/pop): the oldest line sits on the out_ ports while
// out_empty is low and leaves on a cycle with out_pop high. After the last
// row of a puzzle has been classified, the back end emits rows*rows lines,
// one per cycle while the FIFO has room, through a one-line register and a
// four-line FIFO. Loading of the next puzzle can overlap the walk.
// Stalling: if out_pop stays low, the FIFO fills and the walk holds; the
// row queue then fills and in_full rises. Nothing is dropped.
// Config port: cfg_we writes register cfg_index (0 = rows, 1 = columns);
// write only while idle. Reset clears the queues, the row count and the
// running total and sets both registers to 8; stored rows are not cleared.
// ----------------------------------------------------------------------------
module triple_witness_cube_builder_unit import twcb_pkg::*; #(
  parameter int MAX_ROWS_STORED = 8,
  parameter int MAX_DIGITS      = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  // row input
  input  logic              in_push,
  input  logic [ROW_W-1:0]  in_row_value,
  output logic              in_full,
  // cube lines
  input  logic              out_pop,
  output logic              out_empty,
  output logic [IDX_W-1:0]  out_first_index,
  output logic [IDX_W-1:0]  out_second_index,
  output logic [BITS_W-1:0] out_cube_bits,
  output logic [CNT_W-1:0]  out_running_count,
  output logic              out_last_line
);

  localparam int RIDX_W    = (MAX_ROWS_STORED > 1) ? $clog2(MAX_ROWS_STORED) : 1;
  localparam int JOB_W     = 1 + RIDX_W + 3 * MAX_DIGITS;
  localparam int JOB_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  logic [CFG_W-1:0] rows_r, cols_r;
  cfg_t             cfg;

  logic             job_valid, job_full, job_empty, job_pop;
  logic [JOB_W-1:0] job_wdata, job_rdata;
  logic             res_valid, res_full;
  logic [RES_W-1:0] res_wdata, res_rdata;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CFG_W'(8);
      cols_r <= CFG_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_ROWS: rows_r <= cfg_wdata;
        CFG_IDX_COLS: cols_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // zero reads as one, large values clamp to the build limits
  always_comb begin
    if (rows_r == '0) begin
      cfg.rows = CFG_W'(1);
    end else if (rows_r > CFG_W'(MAX_ROWS_STORED)) begin
      cfg.rows = CFG_W'(MAX_ROWS_STORED);
    end else begin
      cfg.rows = rows_r;
    end
    if (cols_r == '0) begin
      cfg.cols = COLS_W'(1);
    end else if (COLS_W'(cols_r) > COLS_W'(MAX_DIGITS)) begin
      cfg.cols = COLS_W'(MAX_DIGITS);
    end else begin
      cfg.cols = COLS_W'(cols_r);
    end
  end

  twcb_front #(
    .ROW_SLOTS  (MAX_ROWS_STORED),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_push      (in_push),
    .in_row_value (in_row_value),
    .in_full      (in_full),
    .job_valid    (job_valid),
    .job_data     (job_wdata),
    .job_ready    (!job_full)
  );

  twcb_queue #(
    .WIDTH (JOB_W),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_valid),
    .push_data (job_wdata),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (job_rdata),
    .empty     (job_empty)
  );

  twcb_back #(
    .ROW_SLOTS  (MAX_ROWS_STORED),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .job_empty (job_empty),
    .job_data  (job_rdata),
    .job_pop   (job_pop),
    .res_valid (res_valid),
    .res_data  (res_wdata),
    .res_ready (!res_full)
  );

  twcb_queue #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res_wdata),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (res_rdata),
    .empty     (out_empty)
  );

  assign {out_first_index, out_second_index, out_cube_bits,
          out_running_count, out_last_line} = res_rdata;

endmodule

// ===== hw/rtl/twcb_checker.sv =====
// ----------------------------------------------------------------------------
// twcb_port_checker: port-level checks on the cube line channel
// Watches the result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module twcb_port_checker import twcb_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_pop,
  input logic              out_empty,
  input logic [IDX_W-1:0]  out_first_index,
  input logic [IDX_W-1:0]  out_second_index,
  input logic [BITS_W-1:0] out_cube_bits,
  input logic [CNT_W-1:0]  out_running_count,
  input logic              out_last_line
);

  // reset drains the result FIFO
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result channel not empty after reset");

  // a stalled line holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_cube_bits) && $stable(out_running_count)))
    else $error("stalled cube line changed");

  // the closing line is the diagonal pair (rows-1, rows-1); checked as equal indexes
  a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_last_line) |-> (out_first_index == out_second_index))
    else $error("last line is not on the diagonal");

  // within a puzzle the running count never drops
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pop && !out_empty && !out_last_line) ##1 !out_empty |->
      (out_running_count >= $past(out_running_count)))
    else $error("running count went down inside a puzzle");

endmodule

bind triple_witness_cube_builder_unit twcb_port_checker u_twcb_checker (.*);

// ===== sim/twcb_checker.sv =====
// ----------------------------------------------------------------------------
// twcb_checker: cube line predictor and scoreboard
// Watches the config, row and cube line ports of the cube builder. It keeps
// its own copy of the registers and the row store, predicts every line of a
// finished puzzle, and compares each popped beat with the oldest prediction.
// ----------------------------------------------------------------------------
module twcb_checker import twcb_pkg::*; #(
  parameter int MAX_ROWS_STORED = 8,
  parameter int MAX_DIGITS      = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_push,
  input  logic              in_full,
  input  logic [ROW_W-1:0]  in_row_value,
  input  logic              out_pop,
  input  logic              out_empty,
  input  logic [IDX_W-1:0]  out_first_index,
  input  logic [IDX_W-1:0]  out_second_index,
  input  logic [BITS_W-1:0] out_cube_bits,
  input  logic [CNT_W-1:0]  out_running_count,
  input  logic              out_last_line,
  output int                fail_count,
  output int                lines_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W-1:0]  first_index;
    logic [IDX_W-1:0]  second_index;
    logic [BITS_W-1:0] cube_bits;
    logic [CNT_W-1:0]  running_count;
    logic              last_line;
  } cube_line_t;

  cube_line_t       cube_lines_due[$];
  logic [ROW_W-1:0] puzzle_rows [MAX_ROWS_STORED];
  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;
  int               rows_filled;
  int               errors = 0;

  // 1 when no examined column holds exactly two of: a digit 0, b digit 1, c digit 2
  function automatic bit triple_free(logic [ROW_W-1:0] a, logic [ROW_W-1:0] b,
                                     logic [ROW_W-1:0] c, int ncols);
    int va;
    int vb;
    int vc;
    int hits;
    va = a;
    vb = b;
    vc = c;
    for (int i = 0; i < ncols; i++) begin
      hits = 0;
      if (va % 3 == 0) hits++;
      if (vb % 3 == 1) hits++;
      if (vc % 3 == 2) hits++;
      if (hits == 2) return 1'b0;
      va = va / 3;
      vb = vb / 3;
      vc = vc / 3;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    int               nrows;
    int               ncols;
    int               slot;
    int               total;
    logic [BITS_W-1:0] mask;
    cube_line_t       want;
    cube_line_t       seen;
    if (!rst_n) begin
      rows_reg    = CFG_W'(8);
      cols_reg    = CFG_W'(8);
      rows_filled = 0;
      cube_lines_due.delete();
    end else begin
      // compare first: a beat on the ports never depends on this edge's row
      if (out_pop && !out_empty) begin
        seen.first_index   = out_first_index;
        seen.second_index  = out_second_index;
        seen.cube_bits     = out_cube_bits;
        seen.running_count = out_running_count;
        seen.last_line     = out_last_line;
        if (cube_lines_due.size() == 0) begin
          if (errors < 10)
            $display("%0t: unexpected cube line r1=%0d r2=%0d bits=%h cnt=%0d last=%0b",
                     $realtime, seen.first_index, seen.second_index, seen.cube_bits,
                     seen.running_count, seen.last_line);
          errors++;
        end else begin
          want = cube_lines_due.pop_front();
          if (want.first_index !== seen.first_index ||
              want.second_index !== seen.second_index ||
              want.cube_bits !== seen.cube_bits ||
              want.running_count !== seen.running_count ||
              want.last_line !== seen.last_line) begin
            if (errors < 10)
              $display({"%0t: cube line error exp r1=%0d r2=%0d bits=%h cnt=%0d last=%0b",
                        " got r1=%0d r2=%0d bits=%h cnt=%0d last=%0b"},
                       $realtime, want.first_index, want.second_index, want.cube_bits,
                       want.running_count, want.last_line, seen.first_index,
                       seen.second_index, seen.cube_bits, seen.running_count,
                       seen.last_line);
            errors++;
          end
        end
      end

      if (cfg_we) begin
        if (cfg_index == CFG_IDX_ROWS) rows_reg = cfg_wdata;
        else cols_reg = cfg_wdata;
      end

      if (in_push && !in_full) begin
        nrows = (rows_reg == '0) ? 1 :
                (int'(rows_reg) > MAX_ROWS_STORED) ? MAX_ROWS_STORED : int'(rows_reg);
        ncols = (cols_reg == '0) ? 1 :
                (int'(cols_reg) > MAX_DIGITS) ? MAX_DIGITS : int'(cols_reg);
        // rows lowered below the fill level: the beat lands in the last slot
        slot = (rows_filled >= nrows) ? nrows - 1 : rows_filled;
        puzzle_rows[slot] = in_row_value;
        rows_filled = slot + 1;
        if (rows_filled == nrows) begin
          total = 0;
          for (int r1 = 0; r1 < nrows; r1++) begin
            for (int r2 = 0; r2 < nrows; r2++) begin
              mask = '0;
              for (int r3 = 0; r3 < nrows; r3++) begin
                if (triple_free(puzzle_rows[r1], puzzle_rows[r2], puzzle_rows[r3], ncols)) begin
                  mask[r3] = 1'b1;
                  total++;
                end
              end
              want.first_index   = IDX_W'(r1);
              want.second_index  = IDX_W'(r2);
              want.cube_bits     = mask;
              want.running_count = CNT_W'(total);
              want.last_line     = (r1 == nrows - 1) && (r2 == nrows - 1);
              cube_lines_due.push_back(want);
            end
          end
          rows_filled = 0;
        end
      end
    end
    fail_count    <= errors;
    lines_pending <= cube_lines_due.size();
  end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: top level for the triple witness cube builder
// Drives puzzle rows in random bursts, pops cube lines on a stall pattern of
// its own and walks the rows/columns registers through several settings,
// extremes included. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import twcb_pkg::*;

  localparam int ROWS_MAX    = 8;
  localparam int DIGITS      = 8;
  localparam int HALF_PERIOD = 6;
  // lets a row in the front end and the two rows its queue can hold drain
  localparam int SETTLE      = 4 * (DIGITS + 1) + 12;
  localparam int RANDOM_ROWS = 430;
  localparam int LIMIT       = 500_000;
  localparam int ROW_MAXVAL  = (1 << ROW_W) - 1;

  typedef enum int {POP_STEADY, POP_HALF, POP_SPARSE, POP_PATTERN} pop_mode_t;
  typedef enum int {ROW_NOISE, ROW_DIGITS, ROW_BIASED} row_style_t;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              cfg_we       = 1'b0;
  logic              cfg_index    = CFG_IDX_ROWS;
  logic [CFG_W-1:0]  cfg_wdata    = '0;
  logic              in_push      = 1'b0;
  logic [ROW_W-1:0]  in_row_value = '0;
  logic              out_pop      = 1'b0;
  logic              in_full;
  logic              out_empty;
  logic [IDX_W-1:0]  out_first_index;
  logic [IDX_W-1:0]  out_second_index;
  logic [BITS_W-1:0] out_cube_bits;
  logic [CNT_W-1:0]  out_running_count;
  logic              out_last_line;
  int                fail_count;
  int                lines_pending;

  logic [ROW_W-1:0]  row_q[$];        // rows waiting to be pushed
  int                burst_left   = 4;
  int                random_rows  = 0;
  int                cycle_count  = 0;
  pop_mode_t         pop_mode     = POP_STEADY;
  int                pop_window   = 0;
  logic [7:0]        pop_pattern  = 8'hff;

  always begin
    clk = 1'b1;
    #HALF_PERIOD;
    clk = 1'b0;
    #HALF_PERIOD;
  end

  triple_witness_cube_builder_unit #(
    .MAX_ROWS_STORED(ROWS_MAX),
    .MAX_DIGITS     (DIGITS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_push          (in_push),
    .in_row_value     (in_row_value),
    .in_full          (in_full),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_first_index  (out_first_index),
    .out_second_index (out_second_index),
    .out_cube_bits    (out_cube_bits),
    .out_running_count(out_running_count),
    .out_last_line    (out_last_line)
  );

  twcb_checker #(
    .MAX_ROWS_STORED(ROWS_MAX),
    .MAX_DIGITS     (DIGITS)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_row_value     (in_row_value),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_first_index  (out_first_index),
    .out_second_index (out_second_index),
    .out_cube_bits    (out_cube_bits),
    .out_running_count(out_running_count),
    .out_last_line    (out_last_line),
    .fail_count       (fail_count),
    .lines_pending    (lines_pending)
  );

  // Hard stop in case the block hangs or keeps lines back.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("triple_witness_cube_builder_unit: mismatch");
      $finish;
    end
  end

  // Receiver: each window of cycles picks a stall style. Steady windows give
  // stretches with no stalls; sparse ones back the FIFO up until in_full
  // rises; the rotating pattern lands stalls on fixed phases of the walk.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (pop_window == 0) begin
        pop_mode    = pop_mode_t'($urandom_range(0, 3));
        pop_window  = $urandom_range(20, 80);
        pop_pattern = 8'($urandom_range(1, 255));
      end
      pop_window--;
      case (pop_mode)
        POP_STEADY: out_pop <= 1'b1;
        POP_HALF:   out_pop <= 1'($urandom_range(0, 1));
        POP_SPARSE: out_pop <= ($urandom_range(0, 3) == 0);
        default: begin
          out_pop     <= pop_pattern[0];
          pop_pattern = {pop_pattern[0], pop_pattern[7:1]};
        end
      endcase
    end
  end

  // One puzzle row. Low ncols digits are the entries; the rest of the value
  // is filled with random upper digits that the block has to ignore.
  function automatic logic [ROW_W-1:0] make_row(int ncols, row_style_t style);
    int low;
    int weight;
    int favored;
    int digit;
    int span;
    if (style == ROW_NOISE) return ROW_W'($urandom_range(0, ROW_MAXVAL));
    low     = 0;
    weight  = 1;
    favored = $urandom_range(0, 2);
    for (int i = 0; i < ncols; i++) begin
      // biased rows repeat one digit, which leaves more triples witness-free
      if (style == ROW_BIASED && $urandom_range(0, 3) != 0) digit = favored;
      else digit = $urandom_range(0, 2);
      low    = low + digit * weight;
      weight = weight * 3;
    end
    span = (ROW_MAXVAL - low) / weight;
    return ROW_W'(low + weight * $urandom_range(0, span));
  endfunction

  // Push every row in row_q. in_push stays high across a burst; a burst ends
  // with push low before the next beat, so push is never lowered and raised
  // in the same step.
  task automatic send_rows();
    while (row_q.size() != 0) begin
      in_row_value <= row_q.pop_front();
      in_push      <= 1'b1;
      do @(posedge clk); while (in_full);
      burst_left--;
      if (burst_left <= 0 || row_q.size() == 0) begin
        in_push <= 1'b0;
        if (burst_left <= 0)
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
        repeat (($urandom_range(0, 7) == 0) ? $urandom_range(15, 40)
                                            : $urandom_range(1, 10)) @(posedge clk);
      end
    end
  endtask

  // Every predicted line is back, then let rows still in the front end drain.
  task automatic wait_idle();
    do @(posedge clk); while (lines_pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Both registers, one beat each on back-to-back edges.
  task automatic set_regs(int rows, int cols);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_ROWS;
    cfg_wdata <= CFG_W'(rows);
    @(posedge clk);
    cfg_index <= CFG_IDX_COLS;
    cfg_wdata <= CFG_W'(cols);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    int         r_reg;
    int         c_reg;
    int         eff_r;
    int         eff_c;
    int         n_rows;
    row_style_t style;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting, 8 rows x 8 digits: all zeros, all ones, all twos,
    // the largest 13-bit value, a value with only a digit above the columns.
    row_q = '{13'd0, 13'd3280, 13'd6560, 13'd8191, 13'd6561, 13'd1, 13'd2, 13'd4921};
    send_rows();

    // Zero in both registers acts as one row and one digit.
    wait_idle();
    set_regs(0, 0);
    row_q = '{13'd0, 13'd1, 13'd8191};
    send_rows();

    // Registers above the maximum saturate to 8 rows, 8 digits.
    wait_idle();
    set_regs(15, 15);
    for (int i = 0; i < 8; i++) row_q.push_back(make_row(DIGITS, ROW_BIASED));
    send_rows();

    // Rows lowered mid-puzzle: three of four loaded, then down to two; the
    // next row overwrites the last slot and finishes the puzzle.
    wait_idle();
    set_regs(4, 2);
    for (int i = 0; i < 3; i++) row_q.push_back(make_row(2, ROW_DIGITS));
    send_rows();
    wait_idle();
    set_regs(2, 2);
    row_q.push_back(make_row(2, ROW_DIGITS));
    send_rows();

    // Single-row puzzles with full columns.
    wait_idle();
    set_regs(1, 8);
    row_q = '{13'd8191, 13'd0};
    send_rows();

    // Random phases: a setting, whole puzzles with random content, and now
    // and then a dangling partial puzzle that the next setting has to absorb.
    while (random_rows < RANDOM_ROWS) begin
      case ($urandom_range(0, 9))
        0:       r_reg = 0;
        1:       r_reg = $urandom_range(9, 15);
        2, 3:    r_reg = 8;
        default: r_reg = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0:       c_reg = 0;
        1:       c_reg = $urandom_range(9, 15);
        2, 3:    c_reg = 8;
        default: c_reg = $urandom_range(1, 8);
      endcase
      eff_r = (r_reg == 0) ? 1 : (r_reg > ROWS_MAX) ? ROWS_MAX : r_reg;
      eff_c = (c_reg == 0) ? 1 : (c_reg > DIGITS) ? DIGITS : c_reg;
      wait_idle();
      set_regs(r_reg, c_reg);
      n_rows = eff_r * $urandom_range(1, (eff_r <= 2) ? 12 : (eff_r <= 4) ? 6 : 3);
      if (eff_r > 1 && $urandom_range(0, 2) == 0) n_rows += $urandom_range(1, eff_r - 1);
      style = ($urandom_range(0, 1) == 0) ? ROW_DIGITS : ROW_BIASED;
      for (int i = 0; i < n_rows; i++)
        row_q.push_back(make_row(eff_c, ($urandom_range(0, 5) == 0) ? ROW_NOISE : style));
      random_rows += n_rows;
      send_rows();
    end

    wait_idle();
    if (fail_count == 0)
      $display("triple_witness_cube_builder_unit: match");
    else
      $display("triple_witness_cube_builder_unit: mismatch");
    $finish;
  end

endmodule
